// ----- rtl/core/ddo_pkg.sv -----
package ddo_pkg;

    // Shared datapath word: covers wheel distances, CORDIC vectors and angles
    localparam int CW = 34;
    typedef logic signed [CW-1:0] t_cval;

    // Shared multiplier widths
    localparam int MW = 34;
    localparam int PW = 2 * MW;
    typedef logic signed [MW-1:0] t_mop;
    typedef logic signed [PW-1:0] t_prod;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IWB = 2'd1;

    // Wheel direction codes
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_FWD  = 2'b01;

    // Fixed constants
    localparam logic [31:0] KINV_Q30    = 32'd652032874;
    localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
    localparam logic [31:0] ONE_Q30     = 32'd1073741824;
    localparam logic [19:0] ONE_MILLION = 20'd1000000;

    // Command into the shared CORDIC unit
    typedef struct packed {
        logic start;
        logic vect;
    } t_cordic_cmd;

    // Arctangent of 2^-i as a binary angle (2^32 per turn)
    function automatic logic [31:0] ddo_atan(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000029;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000003;
            5'd29:   a = 32'h00000001;
            5'd30:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/core/ddo_mul.sv -----
module ddo_mul (
    input  logic            i_clk,
    input  ddo_pkg::t_mop   i_a,
    input  ddo_pkg::t_mop   i_b,
    output ddo_pkg::t_prod  o_prod
);
    import ddo_pkg::*;

    t_prod r_prod;

    // Register the product; the result is valid in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/ddo_sqrt.sv -----
module ddo_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [60:0] i_value,
    output logic        o_done,
    output logic [30:0] o_root
);
    import ddo_pkg::*;

    logic [60:0] r_v;
    logic [61:0] r_res;
    logic [60:0] r_bit;
    logic        r_busy;
    logic        r_done;
    logic [61:0] trial;

    assign trial = r_res + {1'b0, r_bit};

    // Bitwise square root, one trial subtract per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_value;
                r_res  <= '0;
                r_bit  <= {1'b1, 60'b0};
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if ({1'b0, r_v} >= trial) begin
                    r_v   <= r_v - trial[60:0];
                    r_res <= (r_res >> 1) + {1'b0, r_bit};
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[30:0];

endmodule

// ----- rtl/core/ddo_cordic.sv -----
module ddo_cordic #(
    parameter int STEPS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ddo_pkg::t_cordic_cmd i_cmd,
    input  ddo_pkg::t_cval       i_x,
    input  ddo_pkg::t_cval       i_y,
    input  ddo_pkg::t_cval       i_z,
    output logic                 o_done,
    output ddo_pkg::t_cval       o_x,
    output ddo_pkg::t_cval       o_y,
    output ddo_pkg::t_cval       o_z
);
    import ddo_pkg::*;

    localparam logic [4:0] LAST = 5'(STEPS - 1);

    t_cval      r_x;
    t_cval      r_y;
    t_cval      r_z;
    logic [4:0] r_i;
    logic       r_vect;
    logic       r_busy;
    logic       r_done;
    t_cval      sx;
    t_cval      sy;
    t_cval      at;
    logic       dpos;

    assign sx   = r_y >>> r_i;
    assign sy   = r_x >>> r_i;
    assign at   = $signed({2'b00, ddo_atan(r_i)});
    assign dpos = r_vect ? !r_y[CW-1] : !r_z[CW-1];

    // One micro-rotation per cycle; vectoring drives y to zero, rotation drives z
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_x    <= i_x;
                r_y    <= i_y;
                r_z    <= i_z;
                r_vect <= i_cmd.vect;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_vect == dpos) begin
                    r_x <= r_x + sx;
                    r_y <= r_y - sy;
                end else begin
                    r_x <= r_x - sx;
                    r_y <= r_y + sy;
                end
                if (r_vect) begin
                    r_z <= dpos ? r_z + at : r_z - at;
                end else begin
                    r_z <= dpos ? r_z - at : r_z + at;
                end
                r_i <= r_i + 5'd1;
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

// ----- rtl/core/ddo_div.sv -----
module ddo_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [47:0] i_den,
    output logic        o_done,
    output logic        o_over,
    output logic [31:0] o_quo
);
    import ddo_pkg::*;

    logic [47:0] r_rem;
    logic [47:0] r_den;
    logic [31:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic        r_over;
    logic [48:0] shifted;
    logic        ge;

    assign shifted = {r_rem, r_quo[31]};
    assign ge      = shifted >= {1'b0, r_den};

    // Restoring division, one quotient bit per cycle; quotients of 2^32 and up flag over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_over <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                r_rem <= {16'b0, i_num[63:32]};
                r_quo <= i_num[31:0];
                r_cnt <= '0;
                if ({16'b0, i_num[63:32]} >= i_den) begin
                    r_over <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_over <= 1'b0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? 48'(shifted - {1'b0, r_den}) : shifted[47:0];
                r_quo <= {r_quo[30:0], ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_over = r_over;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/core/diff_drive_odometry_update.sv -----
// Channel    Dir  Handshake                      Content
// s_axis     in   s_axis_tvalid / s_axis_tready   wheel ticks, directions, elapsed time
// m_axis     out  m_axis_tvalid / m_axis_tready   pose, velocities; tuser flags
// cfg        in   i_cfg_valid / o_cfg_ready       register index and write data
//
// An item's processing time is set by the square root, the two CORDIC passes and
// the two 32-bit restoring divisions.
// A held (ratio beyond one) or zero-time item skips parts and finishes sooner.
// Input is taken only when idle; the result waits in m_axis until taken.
// Reset is synchronous, active low; pose clears and registers take their defaults.
// Configuration writes are accepted every cycle.
module diff_drive_odometry_update #(
    parameter int CORDIC_STEPS = 24,
    parameter int FRAC_BITS    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] right_count, [31:16] left_count, [33:32] right_direction,
    // [35:34] left_direction, [59:36] elapsed_us, [63:60] zero
    input  logic [63:0]                    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] heading,
    // [127:96] linear_velocity, [159:128] angular_velocity
    output logic [159:0]                   m_axis_tdata,
    // [0] bad_cycle, [1] no_time
    output logic [1:0]                     m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import ddo_pkg::*;

    localparam int LS     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int RS     = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
    localparam int AS     = 32 - FRAC_BITS;
    localparam int POS_SH = 46 - FRAC_BITS;
    localparam int STEPS  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    typedef enum logic [4:0] {
        S_IDLE, S_MR, S_ML, S_DL, S_SUM, S_ABS, S_PLO, S_PHI, S_BAD,
        S_RSQ, S_SQIN, S_SQRT, S_VEC, S_MID, S_ROT, S_PX, S_PY, S_PH,
        S_LMUL, S_LDIV, S_LWAIT, S_AM, S_AM2, S_ADIV, S_AWAIT, S_OUT
    } t_state;

    t_state             r_state;
    logic [31:0]        r_mpt;
    logic [31:0]        r_iwb;
    logic [15:0]        r_rt;
    logic [15:0]        r_lt;
    logic [1:0]         r_rdir;
    logic [1:0]         r_ldir;
    logic [23:0]        r_t;
    logic signed [49:0] r_dr;
    logic signed [49:0] r_dl;
    logic signed [49:0] r_diff;
    logic signed [49:0] r_sum;
    logic [48:0]        r_m;
    t_cval              r_dq;
    logic [63:0]        r_plo;
    logic signed [31:0] r_ratio;
    logic               r_bad;
    t_cval              r_angle;
    logic               r_flip;
    t_cval              r_cos;
    t_cval              r_sin;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic [31:0]        r_heading;
    logic [31:0]        r_lin;
    logic [31:0]        r_ang;

    t_mop               mul_a;
    t_mop               mul_b;
    t_prod              prod;
    logic               sqrt_done;
    logic [30:0]        sqrt_root;
    t_cordic_cmd        cmd;
    t_cval              c_x0;
    t_cval              c_y0;
    t_cval              c_z0;
    logic               c_done;
    t_cval              c_x;
    t_cval              c_y;
    t_cval              c_z;
    logic               div_start;
    logic [63:0]        div_num;
    logic [47:0]        div_den;
    logic               div_done;
    logic               div_over;
    logic [31:0]        div_quo;
    logic [49:0]        thi;
    logic               bad_now;
    logic [31:0]        ratio_mag;
    logic [31:0]        mid;
    t_cval              mid_z;
    logic               mid_flip;
    t_cval              dq_abs;
    t_cval              ang_abs;
    logic signed [49:0] sum_adj;

    // Wheel distance with its direction applied; the -2 pattern counts as reverse
    function automatic logic signed [49:0] apply_dir(input logic [1:0] d,
                                                     input logic [47:0] p);
        logic signed [49:0] v;
        case (d)
            DIR_NONE: v = '0;
            DIR_FWD:  v = $signed({2'b00, p});
            default:  v = -$signed({2'b00, p});
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        logic signed [31:0] r;
        if (v[PW-1:31] == '0 || v[PW-1:31] == '1) begin
            r = v[31:0];
        end else begin
            r = v[PW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return r;
    endfunction

    // Clamp a quotient magnitude at 2^31 - 1 (2^31 when negative) and apply the sign
    function automatic logic [31:0] vel_out(input logic [31:0] q, input logic over,
                                            input logic neg);
        logic [31:0] r;
        if (over || q[31]) begin
            r = neg ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
            r = neg ? 32'(-q) : q;
        end
        return r;
    endfunction

    // Turn-ratio range check and Q30 ratio
    assign thi       = prod[49:0] + {18'b0, r_plo[63:32]};
    assign bad_now   = (thi > 50'd65536) || (thi == 50'd65536 && r_plo[31:0] != '0);
    assign ratio_mag = {1'b0, thi[16:0], r_plo[31:18]};
    assign sum_adj   = r_sum[49] ? r_sum + 50'sd1 : r_sum;

    // Mid-cycle heading folded into the CORDIC range
    assign mid      = r_heading + r_angle[32:1];
    assign mid_flip = ($signed(mid) > $signed(ONE_Q30)) || ($signed(mid) < -$signed(ONE_Q30));
    assign mid_z    = mid_flip ? CW'($signed(mid ^ 32'h80000000)) : CW'($signed(mid));

    assign dq_abs  = r_dq[CW-1] ? -r_dq : r_dq;
    assign ang_abs = r_angle[CW-1] ? -r_angle : r_angle;

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MR:    begin mul_a = MW'(r_rt);         mul_b = MW'(r_mpt);       end
            S_ML:    begin mul_a = MW'(r_lt);         mul_b = MW'(r_mpt);       end
            S_PLO:   begin mul_a = MW'(r_m[31:0]);    mul_b = MW'(r_iwb);       end
            S_PHI:   begin mul_a = MW'(r_m[48:32]);   mul_b = MW'(r_iwb);       end
            S_RSQ:   begin mul_a = MW'(r_ratio);      mul_b = MW'(r_ratio);     end
            S_PX:    begin mul_a = r_dq;              mul_b = r_cos;            end
            S_PY:    begin mul_a = r_dq;              mul_b = r_sin;            end
            S_LMUL:  begin mul_a = dq_abs;            mul_b = MW'(ONE_MILLION); end
            S_AM:    begin mul_a = ang_abs;           mul_b = MW'(TWO_PI_Q29);  end
            S_AM2:   begin mul_a = prod[62:29];       mul_b = MW'(ONE_MILLION); end
            default: begin mul_a = '0;                mul_b = '0;               end
        endcase
    end

    // Commands to the CORDIC unit
    always_comb begin
        cmd.start = 1'b0;
        cmd.vect  = 1'b0;
        c_x0      = '0;
        c_y0      = '0;
        c_z0      = '0;
        if (r_state == S_SQRT && sqrt_done) begin
            cmd.start = 1'b1;
            cmd.vect  = 1'b1;
            c_x0      = CW'(sqrt_root);
            c_y0      = CW'(r_ratio);
        end else if (r_state == S_MID) begin
            cmd.start = 1'b1;
            c_x0      = CW'(KINV_Q30);
            c_z0      = mid_z;
        end
    end

    // Divider operands: linear velocity first, then angular velocity
    assign div_start = (r_state == S_LDIV) || (r_state == S_ADIV);
    assign div_num   = (r_state == S_LDIV) ? 64'(prod[51:0]) << LS : prod[63:0];
    assign div_den   = (r_state == S_LDIV) ? 48'(r_t) << RS : 48'(r_t) << AS;

    ddo_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    ddo_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQIN),
        .i_value (61'h1000000000000000 - prod[60:0]),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    ddo_cordic #(.STEPS(STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_x     (c_x0),
        .i_y     (c_y0),
        .i_z     (c_z0),
        .o_done  (c_done),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_z     (c_z)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_over  (div_over),
        .o_quo   (div_quo)
    );

    // Sequencer, pose state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mpt     <= 32'd17507059;
            r_iwb     <= 32'd65536;
            r_px      <= '0;
            r_py      <= '0;
            r_heading <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MPT: r_mpt <= i_cfg_data;
                    CFG_IWB: r_iwb <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_rt    <= s_axis_tdata[15:0];
                        r_lt    <= s_axis_tdata[31:16];
                        r_rdir  <= s_axis_tdata[33:32];
                        r_ldir  <= s_axis_tdata[35:34];
                        r_t     <= s_axis_tdata[59:36];
                        r_state <= S_MR;
                    end
                end
                S_MR: r_state <= S_ML;
                S_ML: begin
                    r_dr    <= apply_dir(r_rdir, prod[47:0]);
                    r_state <= S_DL;
                end
                S_DL: begin
                    r_dl    <= apply_dir(r_ldir, prod[47:0]);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_diff  <= r_dr - r_dl;
                    r_sum   <= r_dr + r_dl;
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_m     <= r_diff[49] ? 49'(-r_diff) : r_diff[48:0];
                    r_dq    <= CW'(sum_adj >>> 17);
                    r_state <= S_PLO;
                end
                S_PLO: r_state <= S_PHI;
                S_PHI: begin
                    r_plo   <= prod[63:0];
                    r_state <= S_BAD;
                end
                S_BAD: begin
                    r_bad   <= bad_now;
                    r_ratio <= r_diff[49] ? -$signed(ratio_mag) : $signed(ratio_mag);
                    r_angle <= '0;
                    if (bad_now) begin
                        r_state <= S_LMUL;
                    end else if (ratio_mag == '0) begin
                        r_state <= S_MID;
                    end else begin
                        r_state <= S_RSQ;
                    end
                end
                S_RSQ:  r_state <= S_SQIN;
                S_SQIN: r_state <= S_SQRT;
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_state <= S_VEC;
                    end
                end
                S_VEC: begin
                    if (c_done) begin
                        r_angle <= c_z;
                        r_state <= S_MID;
                    end
                end
                S_MID: begin
                    r_flip  <= mid_flip;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (c_done) begin
                        r_cos   <= r_flip ? -c_x : c_x;
                        r_sin   <= r_flip ? -c_y : c_y;
                        r_state <= S_PX;
                    end
                end
                S_PX: r_state <= S_PY;
                S_PY: begin
                    r_px    <= sat32(PW'(r_px) + (prod >>> POS_SH));
                    r_state <= S_PH;
                end
                S_PH: begin
                    r_py      <= sat32(PW'(r_py) + (prod >>> POS_SH));
                    r_heading <= r_heading + r_angle[31:0];
                    r_state   <= S_LMUL;
                end
                S_LMUL: begin
                    if (r_t == '0) begin
                        r_lin   <= '0;
                        r_ang   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_LDIV;
                    end
                end
                S_LDIV: r_state <= S_LWAIT;
                S_LWAIT: begin
                    if (div_done) begin
                        r_lin <= vel_out(div_quo, div_over, r_dq[CW-1]);
                        if (r_bad) begin
                            r_ang   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_AM;
                        end
                    end
                end
                S_AM:   r_state <= S_AM2;
                S_AM2:  r_state <= S_ADIV;
                S_ADIV: r_state <= S_AWAIT;
                S_AWAIT: begin
                    if (div_done) begin
                        r_ang   <= vel_out(div_quo, div_over, r_angle[CW-1]);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {r_ang, r_lin, r_heading, r_py, r_px};
    assign m_axis_tuser  = {(r_t == '0), r_bad};
    assign o_cfg_ready   = 1'b1;

    // Input and output sides are never open together
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    // Delivered result frees the block for the next item
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("block did not return to idle after delivery");

    // Held pose gives no turn rate
    a_bad_no_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[159:128] == '0))
        else $error("turn rate nonzero on a held cycle");

    // Zero elapsed time gives zero velocities
    a_no_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[159:96] == '0))
        else $error("velocity nonzero with zero elapsed time");

endmodule
